>>> rtl/rbe_pkg.sv
// Shared constants, types and width helpers for the rational Bezier evaluator.
package rbe_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int T_FRAC_BITS_DEF = 16;

    localparam int WEIGHT_WIDTH    = 16;
    localparam int CFG_INDEX_WIDTH = 2;

    // Q8.8 weights after reset: 1.0, 9.1 (rounded to 2330/256), 1.0
    localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_START_RST  = 16'd256;
    localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_MIDDLE_RST = 16'd2330;
    localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_END_RST    = 16'd256;

    // Queue between front and back end
    localparam int QUEUE_DEPTH  = 8;
    // Register stages in the front end that may hold a transaction not yet queued
    localparam int FRONT_STAGES = 4;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_WEIGHT_START  = 2'd0,
        CFG_WEIGHT_MIDDLE = 2'd1,
        CFG_WEIGHT_END    = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic almost_full;
    } q_status_t;

    // Basis terms and their sum: (u+t)^2 <= 2^(2F), times a 16-bit weight
    function automatic int basis_width(input int t_frac_bits);
        return 2 * t_frac_bits + WEIGHT_WIDTH;
    endfunction

    // Queue entry: zero flag, denominator, three basis terms, three points
    function automatic int entry_width(input int coord_width, input int t_frac_bits);
        return 1 + 4 * basis_width(t_frac_bits) + 3 * coord_width;
    endfunction

endpackage

>>> rtl/rbe_front.sv
// Front end: accepts transactions, clamps t, forms basis terms and flags a zero denominator.
module rbe_front #(
    parameter int COORD_WIDTH = rbe_pkg::COORD_WIDTH_DEF,
    parameter int T_FRAC_BITS = rbe_pkg::T_FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [T_FRAC_BITS:0]                  t_param,
    input  logic signed [COORD_WIDTH-1:0]         point_start,
    input  logic signed [COORD_WIDTH-1:0]         point_control,
    input  logic signed [COORD_WIDTH-1:0]         point_end,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [rbe_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [rbe_pkg::WEIGHT_WIDTH-1:0]      cfg_data,
    input  rbe_pkg::q_status_t                    q_status,
    output logic                                  push,
    output logic [rbe_pkg::entry_width(COORD_WIDTH, T_FRAC_BITS)-1:0] push_data
);

    localparam int TW = T_FRAC_BITS + 1;
    localparam int PW = 2 * T_FRAC_BITS + 1;
    localparam int WW = rbe_pkg::WEIGHT_WIDTH;
    localparam int DW = rbe_pkg::basis_width(T_FRAC_BITS);
    localparam int C  = COORD_WIDTH;
    localparam logic [TW-1:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

    logic [WW-1:0]   w_start_reg;
    logic [WW-1:0]   w_middle_reg;
    logic [WW-1:0]   w_end_reg;

    logic            accept;
    logic [TW-1:0]   t_sat;

    logic            s0_valid_reg;
    logic [TW-1:0]   s0_t_reg;
    logic [TW-1:0]   s0_u_reg;
    logic [3*C-1:0]  s0_pts_reg;

    logic [2*TW-1:0] uu_full;
    logic [2*TW-1:0] ut_full;
    logic [2*TW-1:0] tt_full;
    logic            s1_valid_reg;
    logic [PW-1:0]   s1_uu_reg;
    logic [PW-1:0]   s1_ut_reg;
    logic [PW-1:0]   s1_tt_reg;
    logic [3*C-1:0]  s1_pts_reg;

    logic [PW+WW-1:0] b0_full;
    logic [PW+WW-1:0] b1_full;
    logic [PW+WW-1:0] b2_full;
    logic            s2_valid_reg;
    logic [DW-1:0]   s2_b0_reg;
    logic [DW-1:0]   s2_b1_reg;
    logic [DW-1:0]   s2_b2_reg;
    logic [3*C-1:0]  s2_pts_reg;

    logic [DW-1:0]   den;
    logic            s3_valid_reg;
    logic            s3_zero_reg;
    logic [DW-1:0]   s3_den_reg;
    logic [DW-1:0]   s3_b0_reg;
    logic [DW-1:0]   s3_b1_reg;
    logic [DW-1:0]   s3_b2_reg;
    logic [3*C-1:0]  s3_pts_reg;

    // Weight registers; always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            w_start_reg  <= rbe_pkg::WEIGHT_START_RST;
            w_middle_reg <= rbe_pkg::WEIGHT_MIDDLE_RST;
            w_end_reg    <= rbe_pkg::WEIGHT_END_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                rbe_pkg::CFG_WEIGHT_START:  w_start_reg  <= cfg_data;
                rbe_pkg::CFG_WEIGHT_MIDDLE: w_middle_reg <= cfg_data;
                rbe_pkg::CFG_WEIGHT_END:    w_end_reg    <= cfg_data;
                default:                    ;
            endcase
        end
    end

    assign busy   = q_status.almost_full;
    assign accept = start && !busy;
    assign t_sat  = (t_param > T_ONE) ? T_ONE : t_param;

    assign uu_full = s0_u_reg * s0_u_reg;
    assign ut_full = s0_u_reg * s0_t_reg;
    assign tt_full = s0_t_reg * s0_t_reg;

    assign b0_full = s1_uu_reg * w_start_reg;
    assign b1_full = s1_ut_reg * w_middle_reg;
    assign b2_full = s1_tt_reg * w_end_reg;

    assign den = s2_b0_reg + s2_b1_reg + s2_b2_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= accept;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        s0_t_reg   <= t_sat;
        s0_u_reg   <= T_ONE - t_sat;
        s0_pts_reg <= {point_start, point_control, point_end};

        // products of two Q1.F values stay within 2^(2F)
        s1_uu_reg  <= uu_full[PW-1:0];
        s1_ut_reg  <= ut_full[PW-1:0];
        s1_tt_reg  <= tt_full[PW-1:0];
        s1_pts_reg <= s0_pts_reg;

        // middle term carries the factor of two
        s2_b0_reg  <= b0_full[DW-1:0];
        s2_b1_reg  <= {b1_full[DW-2:0], 1'b0};
        s2_b2_reg  <= b2_full[DW-1:0];
        s2_pts_reg <= s1_pts_reg;

        s3_den_reg  <= den;
        s3_zero_reg <= (den == '0);
        s3_b0_reg   <= s2_b0_reg;
        s3_b1_reg   <= s2_b1_reg;
        s3_b2_reg   <= s2_b2_reg;
        s3_pts_reg  <= s2_pts_reg;
    end

    assign push      = s3_valid_reg;
    assign push_data = {s3_zero_reg, s3_den_reg, s3_b0_reg, s3_b1_reg, s3_b2_reg, s3_pts_reg};

endmodule

>>> rtl/rbe_queue.sv
// Short FIFO between front and back end; drains one entry per cycle into a registered output.
module rbe_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = rbe_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [WIDTH-1:0]   push_data,
    output rbe_pkg::q_status_t status,
    output logic               out_valid,
    output logic [WIDTH-1:0]   out_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] AFULL_LEVEL = CW'(DEPTH - rbe_pkg::FRONT_STAGES);
    localparam logic [CW-1:0] FULL_LEVEL = CW'(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             out_valid_reg;
    logic [WIDTH-1:0] out_data_reg;
    logic             pop;

    assign pop = (count_reg != '0);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_ADDR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_ADDR) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            count_reg     <= count_next;
            out_valid_reg <= pop;
        end
    end

    always_ff @(posedge clk) begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
        if (pop)
        begin
            out_data_reg <= mem[rd_ptr_reg];
        end
    end

    assign status.almost_full = (count_reg >= AFULL_LEVEL);
    assign out_valid          = out_valid_reg;
    assign out_data           = out_data_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != FULL_LEVEL))
        else $error("queue written while full");

    a_pop_had_entry: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $past(count_reg) != '0)
        else $error("queue output valid without a stored entry");

endmodule

>>> rtl/rbe_back.sv
// Back end: numerator products and sum, then a pipelined restoring divider with rounding.
module rbe_back #(
    parameter int COORD_WIDTH = rbe_pkg::COORD_WIDTH_DEF,
    parameter int T_FRAC_BITS = rbe_pkg::T_FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic [rbe_pkg::entry_width(COORD_WIDTH, T_FRAC_BITS)-1:0] in_data,
    output logic                                  done,
    output logic signed [COORD_WIDTH-1:0]         curve_value,
    output logic                                  weight_sum_zero
);

    localparam int C    = COORD_WIDTH;
    localparam int DW   = rbe_pkg::basis_width(T_FRAC_BITS);
    localparam int EW   = rbe_pkg::entry_width(COORD_WIDTH, T_FRAC_BITS);
    localparam int BLO  = DW / 2;
    localparam int BHI  = DW - BLO;
    localparam int LPW  = BLO + 1 + C;
    localparam int HPW  = BHI + 1 + C;
    localparam int NUMW = DW + C;
    localparam int MAGW = DW + C - 1;
    localparam int LAT  = C + 6;

    logic [DW-1:0]         basis [3];
    logic signed [C-1:0]   point [3];
    logic [DW-1:0]         in_den;
    logic                  in_zero;
    logic signed [LPW-1:0] lo_prod [3];
    logic signed [HPW-1:0] hi_prod [3];

    // multiply stage
    logic                  m_valid_reg;
    logic signed [LPW-1:0] m_lo_reg [3];
    logic signed [HPW-1:0] m_hi_reg [3];
    logic [DW-1:0]         m_den_reg;
    logic                  m_zero_reg;

    // term stage
    logic [NUMW-1:0]       term [3];
    logic                  t_valid_reg;
    logic [NUMW-1:0]       t_term_reg [3];
    logic [DW-1:0]         t_den_reg;
    logic                  t_zero_reg;

    // sum stage
    logic                  s_valid_reg;
    logic [NUMW-1:0]       s_sum_reg;
    logic [DW-1:0]         s_den_reg;
    logic                  s_zero_reg;

    // magnitude stage
    logic [NUMW-1:0]       abs_full;
    logic                  a_valid_reg;
    logic [MAGW-1:0]       a_mag_reg;
    logic                  a_neg_reg;
    logic [DW-1:0]         a_den_reg;
    logic                  a_zero_reg;

    // divider stages, one quotient bit each
    logic [DW-1:0]         d_rem_in [C];
    logic [C-1:0]          d_lq_in  [C];
    logic [DW-1:0]         d_den_in [C];
    logic                  d_neg_in [C];
    logic                  d_zero_in [C];
    logic                  d_valid_in [C];
    logic [DW:0]           d_trial [C];
    logic                  d_ge [C];
    logic [DW-1:0]         d_rem_reg [C];
    logic [C-1:0]          d_lq_reg  [C];
    logic [DW-1:0]         d_den_reg [C];
    logic                  d_neg_reg [C];
    logic                  d_zero_reg [C];
    logic                  d_valid_reg [C];

    // rounding and output
    logic                  round_up;
    logic                  r_valid_reg;
    logic [C-1:0]          r_quot_reg;
    logic                  r_neg_reg;
    logic                  r_zero_reg;
    logic                  done_reg;
    logic [C-1:0]          value_reg;
    logic                  zero_out_reg;

    always_comb begin
        in_zero  = in_data[EW-1];
        in_den   = in_data[3*C+4*DW-1 -: DW];
        basis[0] = in_data[3*C+3*DW-1 -: DW];
        basis[1] = in_data[3*C+2*DW-1 -: DW];
        basis[2] = in_data[3*C+DW-1 -: DW];
        point[0] = in_data[3*C-1 -: C];
        point[1] = in_data[2*C-1 -: C];
        point[2] = in_data[C-1 -: C];
        for (int k = 0; k < 3; k++)
        begin
            lo_prod[k] = $signed({1'b0, basis[k][BLO-1:0]}) * point[k];
            hi_prod[k] = $signed({1'b0, basis[k][DW-1:BLO]}) * point[k];
        end
    end

    // term = hi * 2^BLO + lo, exact in NUMW signed bits
    always_comb begin
        for (int k = 0; k < 3; k++)
        begin
            term[k] = {{(NUMW-HPW){m_hi_reg[k][HPW-1]}}, m_hi_reg[k]} << BLO;
            term[k] = term[k] + {{(NUMW-LPW){m_lo_reg[k][LPW-1]}}, m_lo_reg[k]};
        end
    end

    assign abs_full = s_sum_reg[NUMW-1] ? (~s_sum_reg + 1'b1) : s_sum_reg;

    // long division: initial remainder is the top of the magnitude, below the divisor
    always_comb begin
        d_rem_in[0]   = {1'b0, a_mag_reg[MAGW-1:C]};
        d_lq_in[0]    = a_mag_reg[C-1:0];
        d_den_in[0]   = a_den_reg;
        d_neg_in[0]   = a_neg_reg;
        d_zero_in[0]  = a_zero_reg;
        d_valid_in[0] = a_valid_reg;
        for (int i = 1; i < C; i++)
        begin
            d_rem_in[i]   = d_rem_reg[i-1];
            d_lq_in[i]    = d_lq_reg[i-1];
            d_den_in[i]   = d_den_reg[i-1];
            d_neg_in[i]   = d_neg_reg[i-1];
            d_zero_in[i]  = d_zero_reg[i-1];
            d_valid_in[i] = d_valid_reg[i-1];
        end
        for (int i = 0; i < C; i++)
        begin
            d_trial[i] = {d_rem_in[i], d_lq_in[i][C-1]};
            d_ge[i]    = (d_trial[i] >= {1'b0, d_den_in[i]});
        end
    end

    // half or more of the divisor left over rounds the magnitude up
    assign round_up = ({d_rem_reg[C-1], 1'b0} >= {1'b0, d_den_reg[C-1]});

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            t_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            a_valid_reg <= 1'b0;
            for (int i = 0; i < C; i++)
            begin
                d_valid_reg[i] <= 1'b0;
            end
            r_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            m_valid_reg <= in_valid;
            t_valid_reg <= m_valid_reg;
            s_valid_reg <= t_valid_reg;
            a_valid_reg <= s_valid_reg;
            for (int i = 0; i < C; i++)
            begin
                d_valid_reg[i] <= d_valid_in[i];
            end
            r_valid_reg <= d_valid_reg[C-1];
            done_reg    <= r_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        for (int k = 0; k < 3; k++)
        begin
            m_lo_reg[k]   <= lo_prod[k];
            m_hi_reg[k]   <= hi_prod[k];
            t_term_reg[k] <= term[k];
        end
        m_den_reg  <= in_den;
        m_zero_reg <= in_zero;
        t_den_reg  <= m_den_reg;
        t_zero_reg <= m_zero_reg;

        s_sum_reg  <= t_term_reg[0] + t_term_reg[1] + t_term_reg[2];
        s_den_reg  <= t_den_reg;
        s_zero_reg <= t_zero_reg;

        a_mag_reg  <= abs_full[MAGW-1:0];
        a_neg_reg  <= s_sum_reg[NUMW-1];
        a_den_reg  <= s_den_reg;
        a_zero_reg <= s_zero_reg;

        for (int i = 0; i < C; i++)
        begin
            d_rem_reg[i]  <= d_ge[i] ? DW'(d_trial[i] - {1'b0, d_den_in[i]})
                                     : d_trial[i][DW-1:0];
            d_lq_reg[i]   <= {d_lq_in[i][C-2:0], d_ge[i]};
            d_den_reg[i]  <= d_den_in[i];
            d_neg_reg[i]  <= d_neg_in[i];
            d_zero_reg[i] <= d_zero_in[i];
        end

        r_quot_reg <= d_lq_reg[C-1] + C'(round_up);
        r_neg_reg  <= d_neg_reg[C-1];
        r_zero_reg <= d_zero_reg[C-1];

        if (r_zero_reg)
        begin
            value_reg <= '0;
        end
        else if (r_neg_reg)
        begin
            value_reg <= ~r_quot_reg + 1'b1;
        end
        else
        begin
            value_reg <= r_quot_reg;
        end
        zero_out_reg <= r_zero_reg;
    end

    assign done            = done_reg;
    assign curve_value     = value_reg;
    assign weight_sum_zero = zero_out_reg;

    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> ##(LAT) done_reg)
        else $error("queued entry did not produce a result at the pipeline depth");

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(in_valid, LAT))
        else $error("result without a matching queued entry");

    a_remainder_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (d_valid_reg[C-1] && d_den_reg[C-1] != '0) |-> (d_rem_reg[C-1] < d_den_reg[C-1]))
        else $error("division remainder not below the denominator");

endmodule

>>> rtl/rational_bezier_evaluator.sv
// Top level of the rational quadratic Bezier evaluator (one coordinate).
//
//  channel  | handshake            | payload                                   | direction
//  ---------+----------------------+-------------------------------------------+----------
//  item     | start, busy          | t_param, point_start/control/end          | in
//  result   | done (strobe)        | curve_value, weight_sum_zero              | out
//  config   | cfg_valid, cfg_ready | cfg_index, cfg_data (Q8.8 weights)        | in
//
// One transaction is taken per cycle while busy is low. From the accepting edge to the done
// strobe, a transaction passes four front-end register stages, the queue, and six
// back-end register stages around the one-bit-per-stage divider (COORD_WIDTH stages).
// Reset (rst_n low, asynchronous) empties every stage and the queue and loads the
// weights with 1.0, 9.1, 1.0. There is no clearing pass.
// busy follows the queue's almost-full level; the back end drains one entry a cycle,
// so it stays low in use. The receiver cannot stall: done is high for exactly one cycle.
module rational_bezier_evaluator #(
    parameter int COORD_WIDTH = rbe_pkg::COORD_WIDTH_DEF,
    parameter int T_FRAC_BITS = rbe_pkg::T_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // item channel
    input  logic                                start,
    output logic                                busy,
    input  logic [T_FRAC_BITS:0]                t_param,
    input  logic signed [COORD_WIDTH-1:0]       point_start,
    input  logic signed [COORD_WIDTH-1:0]       point_control,
    input  logic signed [COORD_WIDTH-1:0]       point_end,
    // result channel
    output logic                                done,
    output logic signed [COORD_WIDTH-1:0]       curve_value,
    output logic                                weight_sum_zero,
    // configuration channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rbe_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [rbe_pkg::WEIGHT_WIDTH-1:0]    cfg_data
);

    localparam int EW = rbe_pkg::entry_width(COORD_WIDTH, T_FRAC_BITS);

    // front to queue
    logic               push;
    logic [EW-1:0]      push_data;
    rbe_pkg::q_status_t q_status;

    // queue to back
    logic               q_valid;
    logic [EW-1:0]      q_data;

    // Front end: clamps t to 1.0, builds u = 1 - t, the three weighted basis
    // terms and their sum, and marks a zero denominator before queueing.
    rbe_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .t_param       (t_param),
        .point_start   (point_start),
        .point_control (point_control),
        .point_end     (point_end),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .q_status      (q_status),
        .push          (push),
        .push_data     (push_data)
    );

    // Decoupling queue; its almost-full level leaves room for what is in the front end.
    rbe_queue #(
        .WIDTH (EW),
        .DEPTH (rbe_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .status    (q_status),
        .out_valid (q_valid),
        .out_data  (q_data)
    );

    // Back end: exact signed numerator, magnitude, divide, round half away from
    // zero, restore the sign. A zero denominator forces the value to zero.
    rbe_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (q_valid),
        .in_data         (q_data),
        .done            (done),
        .curve_value     (curve_value),
        .weight_sum_zero (weight_sum_zero)
    );

endmodule
